// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is asserted
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/stbs_pkg.sv =====
// shared types and constants for the sorted table binary search core
`default_nettype none

package stbs_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;
  localparam int DATA_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;

  // request codes, code 7 is unused and acts as a no-op
  typedef enum logic [REQ_W-1:0] {
    REQ_FIND    = 3'd0,
    REQ_ADD     = 3'd1,
    REQ_INCLUDE = 3'd2,
    REQ_REMOVE  = 3'd3,
    REQ_POP     = 3'd4,
    REQ_PEEK    = 3'd5,
    REQ_CLEAR   = 3'd6
  } req_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_CMP,
    S_ACT,
    S_SHIFT,
    S_POP,
    S_FIN
  } state_t;

  // one access to the value store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // one finished result
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [CNT_W-1:0]   position;
    logic [DATA_W-1:0]  read_value;
    logic [CNT_W-1:0]   entry_count;
  } result_t;

endpackage

`default_nettype wire

// ===== src/stbs_mem.sv =====
// value store: one write port, one read port with registered read data
`default_nettype none

module stbs_mem (
  input  wire logic                      clk,
  input  wire stbs_pkg::mem_req_t        mem_req,
  output logic [stbs_pkg::DATA_W-1:0]    rdata
);

  logic [stbs_pkg::DATA_W-1:0] store_r [stbs_pkg::CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      store_r[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= store_r[mem_req.raddr];
  end

endmodule

`default_nettype wire

// ===== src/stbs_ctrl.sv =====
// request sequencer: binary search, entry shifting, pop and peek
`default_nettype none

module stbs_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_accept,
  input  wire logic [stbs_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [stbs_pkg::DATA_W-1:0]   in_value,
  input  wire logic                          out_free,
  output logic                               idle,
  output logic                               done,
  output stbs_pkg::result_t                  res,
  output stbs_pkg::mem_req_t                 mem_req,
  input  wire logic [stbs_pkg::DATA_W-1:0]   mem_rdata
);

  localparam int CW = stbs_pkg::CNT_W;
  localparam int AW = stbs_pkg::ADDR_W;

  stbs_pkg::state_t  state_r, state_nxt;
  stbs_pkg::req_t    req_r, req_nxt;
  logic [stbs_pkg::DATA_W-1:0] key_r, key_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic              found_r, found_nxt;
  logic [stbs_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [stbs_pkg::DATA_W-1:0] readv_r, readv_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_wr_r, pend_wr_nxt;
  logic              ins_r, ins_nxt;
  logic [CW-1:0]     mid_calc;
  logic [CW-1:0]     cnt_m1;

  assign mid_calc = ((hi_r - lo_r) >> 1) + lo_r;
  assign cnt_m1   = count_r - CW'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= stbs_pkg::S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    key_r     <= key_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    pos_r     <= pos_nxt;
    found_r   <= found_nxt;
    status_r  <= status_nxt;
    readv_r   <= readv_nxt;
    src_r     <= src_nxt;
    rem_r     <= rem_nxt;
    pend_wr_r <= pend_wr_nxt;
    ins_r     <= ins_nxt;
  end

  // next state and store accesses
  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    key_nxt     = key_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    readv_nxt   = readv_r;
    count_nxt   = count_r;
    src_nxt     = src_r;
    rem_nxt     = rem_r;
    pend_nxt    = pend_r;
    pend_wr_nxt = pend_wr_r;
    ins_nxt     = ins_r;
    done        = 1'b0;
    mem_req     = '0;

    case (state_r)
      stbs_pkg::S_IDLE: begin
        if (in_accept) begin
          req_nxt    = stbs_pkg::req_t'(in_req_type);
          key_nxt    = in_value;
          lo_nxt     = '0;
          hi_nxt     = count_r;
          pos_nxt    = '0;
          found_nxt  = 1'b0;
          status_nxt = stbs_pkg::ST_OK;
          readv_nxt  = '0;
          case (stbs_pkg::req_t'(in_req_type))
            stbs_pkg::REQ_FIND, stbs_pkg::REQ_ADD,
            stbs_pkg::REQ_INCLUDE, stbs_pkg::REQ_REMOVE: begin
              state_nxt = stbs_pkg::S_SRCH;
            end
            stbs_pkg::REQ_POP, stbs_pkg::REQ_PEEK: begin
              if (count_r == '0) begin
                status_nxt = stbs_pkg::ST_EMPTY;
                state_nxt  = stbs_pkg::S_FIN;
              end else begin
                mem_req.raddr = cnt_m1[AW-1:0];
                state_nxt     = stbs_pkg::S_POP;
              end
            end
            stbs_pkg::REQ_CLEAR: begin
              count_nxt = '0;
              state_nxt = stbs_pkg::S_FIN;
            end
            default: begin
              state_nxt = stbs_pkg::S_FIN;
            end
          endcase
        end
      end

      // issue the midpoint read, or settle on the insertion point
      stbs_pkg::S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt       = mid_calc;
          mem_req.raddr = mid_calc[AW-1:0];
          state_nxt     = stbs_pkg::S_CMP;
        end else begin
          pos_nxt   = lo_r;
          found_nxt = 1'b0;
          state_nxt = stbs_pkg::S_ACT;
        end
      end

      // signed compare of the key against the midpoint entry
      stbs_pkg::S_CMP: begin
        if (key_r == mem_rdata) begin
          pos_nxt   = mid_r;
          found_nxt = 1'b1;
          state_nxt = stbs_pkg::S_ACT;
        end else if ($signed(key_r) > $signed(mem_rdata)) begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = stbs_pkg::S_SRCH;
        end else begin
          hi_nxt    = mid_r;
          state_nxt = stbs_pkg::S_SRCH;
        end
      end

      // decide on insert, delete or nothing after the search
      stbs_pkg::S_ACT: begin
        pend_nxt  = 1'b0;
        state_nxt = stbs_pkg::S_FIN;
        case (req_r)
          stbs_pkg::REQ_ADD, stbs_pkg::REQ_INCLUDE: begin
            if (req_r == stbs_pkg::REQ_ADD || !found_r) begin
              if (count_r >= CW'(stbs_pkg::CAPACITY)) begin
                status_nxt = stbs_pkg::ST_FULL;
              end else begin
                ins_nxt   = 1'b1;
                rem_nxt   = count_r - pos_r;
                src_nxt   = cnt_m1[AW-1:0];
                state_nxt = stbs_pkg::S_SHIFT;
              end
            end
          end
          stbs_pkg::REQ_REMOVE: begin
            if (found_r) begin
              ins_nxt   = 1'b0;
              rem_nxt   = cnt_m1 - pos_r;
              src_nxt   = pos_r[AW-1:0] + AW'(1);
              state_nxt = stbs_pkg::S_SHIFT;
            end
          end
          default: begin
            state_nxt = stbs_pkg::S_FIN;
          end
        endcase
      end

      // move one entry per cycle: read one address, write the one read before
      stbs_pkg::S_SHIFT: begin
        if (pend_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = pend_wr_r;
          mem_req.wdata = mem_rdata;
        end
        if (rem_r != '0) begin
          mem_req.raddr = src_r;
          pend_nxt      = 1'b1;
          pend_wr_nxt   = ins_r ? (src_r + AW'(1)) : (src_r - AW'(1));
          src_nxt       = ins_r ? (src_r - AW'(1)) : (src_r + AW'(1));
          rem_nxt       = rem_r - CW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          if (ins_r) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = pos_r[AW-1:0];
            mem_req.wdata = key_r;
            count_nxt     = count_r + CW'(1);
          end else begin
            count_nxt = cnt_m1;
          end
          state_nxt = stbs_pkg::S_FIN;
        end
      end

      // last entry read back for pop and peek
      stbs_pkg::S_POP: begin
        readv_nxt = mem_rdata;
        if (req_r == stbs_pkg::REQ_POP) begin
          count_nxt = cnt_m1;
        end
        state_nxt = stbs_pkg::S_FIN;
      end

      // hand the result over once the output register is free
      stbs_pkg::S_FIN: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = stbs_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = stbs_pkg::S_IDLE;
      end
    endcase
  end

  // result and status toward the top level
  assign idle            = (state_r == stbs_pkg::S_IDLE);
  assign res.status      = status_r;
  assign res.found       = found_r;
  assign res.position    = pos_r;
  assign res.read_value  = readv_r;
  assign res.entry_count = count_r;

endmodule

`default_nettype wire

// ===== src/sorted_table_binary_search_core.sv =====
// Sorted table core: keeps up to 256 signed 32-bit values in ascending order.
// Input channel in_valid/in_stall carries one request (type and value); the
// core stalls it while a request is in work and takes one request at a time.
// Result channel out_valid/out_stall returns one result per request from an
// output register, so a new request is taken while a result still waits.
// Work per request, with n = entries in the table:
//   find/include-present/absent-remove: a binary search over the n entries
//   add/include/remove that moves k entries: the search, then k moves, or
//   the search alone when nothing moves; at most 255 entries move
//   pop/peek: a read of the last entry, none if empty; clear/no-op: none
// Requests do not overlap: the next request is taken only once the
// sequencer is back in idle, which it enters as the result is registered.
// Request time is set by the search loop and the shift loop, which both run
// through the single read port of the value store, one access per cycle.
// Reset (rst_n low, synchronous) empties the table and drops any result;
// store contents are not cleared, entries above the count are never read.
// When out_stall is high the result holds, and a finished request waits in
// the sequencer until the output register is free.
`default_nettype none

module sorted_table_binary_search_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [stbs_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [stbs_pkg::DATA_W-1:0]   in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [stbs_pkg::STAT_W-1:0]        out_status,
  output logic                               out_found,
  output logic [stbs_pkg::CNT_W-1:0]         out_position,
  output logic [stbs_pkg::DATA_W-1:0]        out_read_value,
  output logic [stbs_pkg::CNT_W-1:0]         out_entry_count
);

  logic                        idle;
  logic                        done;
  logic                        in_accept;
  logic                        out_free;
  stbs_pkg::result_t           res;
  stbs_pkg::mem_req_t          mem_req;
  logic [stbs_pkg::DATA_W-1:0] mem_rdata;
  logic                        out_valid_r;
  stbs_pkg::result_t           out_res_r;

  // request handshake
  assign in_stall  = !idle;
  assign in_accept = in_valid && idle;
  assign out_free  = !out_valid_r || !out_stall;

  stbs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .in_req_type (in_req_type),
    .in_value    (in_value),
    .out_free    (out_free),
    .idle        (idle),
    .done        (done),
    .res         (res),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

  stbs_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (done) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_found       = out_res_r.found;
  assign out_position    = out_res_r.position;
  assign out_read_value  = out_res_r.read_value;
  assign out_entry_count = out_res_r.entry_count;

endmodule

`default_nettype wire

// ===== src/stbs_chk.sv =====
// port-level checker for the sorted table core, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module stbs_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [stbs_pkg::REQ_W-1:0]    in_req_type,
  input wire logic [stbs_pkg::DATA_W-1:0]   in_value,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [stbs_pkg::STAT_W-1:0]   out_status,
  input wire logic                          out_found,
  input wire logic [stbs_pkg::CNT_W-1:0]    out_position,
  input wire logic [stbs_pkg::DATA_W-1:0]   out_read_value,
  input wire logic [stbs_pkg::CNT_W-1:0]    out_entry_count
);

  // a stalled result stays valid
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped under stall")

  // the core is busy in the cycle after it takes a request
  `ASSERT_CLK(a_busy_after_req, clk, rst_n, in_valid && !in_stall |=> in_stall, "request taken while busy")

  // an empty status reports an empty table and no read value
  `ASSERT_CLK(a_empty_result, clk, rst_n, out_valid && out_status == stbs_pkg::ST_EMPTY |-> out_entry_count == '0 && out_read_value == '0 && !out_found, "bad empty result")

  // a full status reports a full table, and count never exceeds capacity
  `ASSERT_CLK(a_full_result, clk, rst_n, out_valid |-> out_entry_count <= stbs_pkg::CNT_W'(stbs_pkg::CAPACITY) && (out_status != stbs_pkg::ST_FULL || out_entry_count == stbs_pkg::CNT_W'(stbs_pkg::CAPACITY)), "bad entry count")

  // no result is offered while reset is held
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sorted_table_binary_search_core stbs_chk u_stbs_chk (.*);

`default_nettype wire

// ===== dv/tb_sorted_table_binary_search_core.sv =====
`timescale 1ns / 100ps
// testbench for the sorted table core: directed request table, then random request sequences
module tb_sorted_table_binary_search_core;
  import stbs_pkg::*;

  // unused request code, answered as a no-op
  localparam logic [REQ_W-1:0] REQ_NOP = 3'd7;
  localparam int RANDOM_REQS = 1430;
  localparam int TAIL_CYCLES = 300;

  // one directed request, with its answer typed in where it is obvious
  typedef struct packed {
    logic [REQ_W-1:0]  code;
    logic [DATA_W-1:0] val;
    logic              typed;
    result_t           res;
  } dir_row_t;

  localparam int N_DIRECTED = 24;
  localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{REQ_FIND,    32'd0,         1'b1, '{ST_OK,    1'b0, 9'd0, 32'd0, 9'd0}},
    '{REQ_POP,     32'hFFFF_FFFF, 1'b1, '{ST_EMPTY, 1'b0, 9'd0, 32'd0, 9'd0}},
    '{REQ_PEEK,    32'd0,         1'b1, '{ST_EMPTY, 1'b0, 9'd0, 32'd0, 9'd0}},
    '{REQ_REMOVE,  32'd5,         1'b1, '{ST_OK,    1'b0, 9'd0, 32'd0, 9'd0}},
    '{REQ_ADD,     32'h8000_0000, 1'b1, '{ST_OK,    1'b0, 9'd0, 32'd0, 9'd1}},
    '{REQ_ADD,     32'h7FFF_FFFF, 1'b1, '{ST_OK,    1'b0, 9'd1, 32'd0, 9'd2}},
    '{REQ_ADD,     32'd0,         1'b0, '0},
    '{REQ_ADD,     32'd0,         1'b0, '0},
    '{REQ_INCLUDE, 32'd0,         1'b0, '0},
    '{REQ_INCLUDE, 32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_FIND,    32'h7FFF_FFFF, 1'b0, '0},
    '{REQ_FIND,    32'd1,         1'b0, '0},
    '{REQ_REMOVE,  32'd1,         1'b0, '0},
    '{REQ_REMOVE,  32'd0,         1'b0, '0},
    '{REQ_FIND,    32'h8000_0000, 1'b0, '0},
    '{REQ_PEEK,    32'h5555_5555, 1'b0, '0},
    '{REQ_POP,     32'hAAAA_AAAA, 1'b0, '0},
    '{REQ_NOP,     32'hFFFF_FFFF, 1'b0, '0},
    '{REQ_INCLUDE, 32'h8000_0000, 1'b0, '0},
    '{REQ_CLEAR,   32'hFFFF_FFFF, 1'b1, '{ST_OK,    1'b0, 9'd0, 32'd0, 9'd0}},
    '{REQ_PEEK,    32'd0,         1'b1, '{ST_EMPTY, 1'b0, 9'd0, 32'd0, 9'd0}},
    '{REQ_NOP,     32'd0,         1'b1, '{ST_OK,    1'b0, 9'd0, 32'd0, 9'd0}},
    '{REQ_ADD,     32'h7FFF_FFFF, 1'b1, '{ST_OK,    1'b0, 9'd0, 32'd0, 9'd1}},
    '{REQ_REMOVE,  32'h7FFF_FFFF, 1'b1, '{ST_OK,    1'b1, 9'd0, 32'd0, 9'd0}}
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  in_req_type = '0;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic              out_found;
  logic [CNT_W-1:0]  out_position;
  logic [DATA_W-1:0] out_read_value;
  logic [CNT_W-1:0]  out_entry_count;

  // shadow copy of the sorted table
  logic [DATA_W-1:0] held [CAPACITY];
  int                held_count = 0;

  result_t     table_responses [$];
  int          items_sent = 0;
  int          error_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  always #5 clk = ~clk;

  sorted_table_binary_search_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found       (out_found),
    .out_position    (out_position),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count)
  );

  // search the shadow table, apply the request and return its answer
  function automatic result_t apply_table_request(input logic [REQ_W-1:0] code,
                                                  input logic [DATA_W-1:0] val);
    result_t res;
    int      lo;
    int      hi;
    int      mid;
    int      pos;
    bit      hit;
    res = '0;
    if (code <= REQ_REMOVE) begin
      lo  = 0;
      hi  = held_count;
      mid = 0;
      hit = 1'b0;
      // signed compare, midpoint rounds toward lo
      while (lo < hi && !hit) begin
        mid = (hi - lo) / 2 + lo;
        if (held[mid] == val) hit = 1'b1;
        else if ($signed(val) > $signed(held[mid])) lo = mid + 1;
        else hi = mid;
      end
      pos = hit ? mid : lo;
      res.position = CNT_W'(pos);
      res.found    = hit;
      if (code == REQ_ADD || (code == REQ_INCLUDE && !hit)) begin
        if (held_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int j = held_count; j > pos; j--) held[j] = held[j-1];
          held[pos] = val;
          held_count++;
        end
      end else if (code == REQ_REMOVE && hit) begin
        for (int j = pos + 1; j < held_count; j++) held[j-1] = held[j];
        held_count--;
      end
    end else if (code == REQ_POP || code == REQ_PEEK) begin
      if (held_count == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.read_value = held[held_count-1];
        if (code == REQ_POP) held_count--;
      end
    end else if (code == REQ_CLEAR) begin
      held_count = 0;
    end
    res.entry_count = CNT_W'(held_count);
    return res;
  endfunction

  // value mix: stored entries, a narrow band around zero, extremes, anything
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45 && held_count != 0) return held[$urandom_range(held_count - 1)];
    if (r < 75) return DATA_W'(int'($urandom_range(40)) - 20);
    if (r < 85) begin
      case ($urandom_range(3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h8000_0001;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom();
  endfunction

  // present one request and hold it until taken
  task automatic send_request(input logic [REQ_W-1:0] code, input logic [DATA_W-1:0] val,
                              input bit typed = 1'b0, input result_t typed_res = '0);
    result_t answer;
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= code;
    in_value    <= val;
    do @(posedge clk); while (in_stall);
    answer = apply_table_request(code, val);
    table_responses.push_back(typed ? typed_res : answer);
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending until every answer is back, returns at a rising edge
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (table_responses.size() != 0);
  endtask

  // receiver stalls
  always @(negedge clk) begin
    out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
  end

  // compare each taken answer with the oldest one waiting
  always @(posedge clk) begin : check_responses
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (table_responses.size() == 0) begin
        $error("answer with no request outstanding");
        error_count++;
      end else begin
        want = table_responses.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          error_count++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_position);
          error_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d",
                 $signed(want.read_value), $signed(out_read_value));
          error_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [REQ_W-1:0] code;
    int unsigned      r;
    int               seq_idx;
    bit               heavy;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed requests
    for (int i = 0; i < N_DIRECTED; i++) begin
      send_request(DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].val,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end

    // random request sequences
    seq_idx = 0;
    while (items_sent < N_DIRECTED + RANDOM_REQS) begin
      // new idling phase every third sequence, drained first
      if (seq_idx % 3 == 0) begin
        wait_for_drain();
        case ((seq_idx / 3) % 4)
          0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
          1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
          2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
          default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
        endcase
        @(negedge clk);
      end
      r = $urandom_range(99);
      if (seq_idx == 0 || seq_idx == 30) begin
        // fill to capacity, then the full-table answers
        while (held_count < CAPACITY) send_request(REQ_ADD, pick_value());
        send_request(REQ_ADD, 32'h8000_0000);
        send_request(REQ_INCLUDE, held[$urandom_range(CAPACITY - 1)]);
        send_request(REQ_INCLUDE, $urandom());
        send_request(REQ_ADD, 32'h7FFF_FFFF);
        send_request(REQ_FIND, pick_value());
        send_request(REQ_REMOVE, held[$urandom_range(CAPACITY - 1)]);
        send_request(REQ_INCLUDE, held[0]);
        send_request(REQ_ADD, pick_value());
        send_request(REQ_PEEK, $urandom());
        send_request(REQ_POP, $urandom());
      end else if (r < 10) begin
        // empty the table by pops or a clear, then hit the empty cases
        if (held_count < 64) begin
          repeat (held_count + 2) send_request(REQ_POP, $urandom());
        end else begin
          send_request(REQ_CLEAR, $urandom());
          send_request(REQ_POP, $urandom());
        end
        send_request(REQ_PEEK, $urandom());
        send_request(REQ_REMOVE, pick_value());
      end else if (r < 20) begin
        // any code with any value
        repeat ($urandom_range(6, 12)) send_request(REQ_W'($urandom_range(7)), $urandom());
      end else begin
        // table traffic, leaning to removal when nearly full
        repeat ($urandom_range(16, 32)) begin
          heavy = held_count >= 192;
          r = $urandom_range(99);
          if (r < (heavy ? 15 : 32)) code = REQ_ADD;
          else if (r < (heavy ? 25 : 46)) code = REQ_INCLUDE;
          else if (r < 64) code = REQ_FIND;
          else if (r < 82) code = REQ_REMOVE;
          else if (r < 88) code = REQ_POP;
          else if (r < 94) code = REQ_PEEK;
          else if (r < 97) code = REQ_NOP;
          else code = REQ_FIND;
          send_request(code, pick_value());
        end
      end
      seq_idx++;
    end

    // let everything come back, then a short tail
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/stbs_pkg.sv
src/stbs_mem.sv
src/stbs_ctrl.sv
src/sorted_table_binary_search_core.sv
src/stbs_chk.sv
dv/tb_sorted_table_binary_search_core.sv
